@@ hw/rtl/ttmq_pkg.sv @@
// ----------------------------------------------------------------------------
// ttmq_pkg: shared types and constants of the tournament tree max queue
// Sizes of the tree and key store, action codes and controller interfaces.
// ----------------------------------------------------------------------------
package ttmq_pkg;

  localparam int LEAF_COUNT = 1024;
  localparam int KEY_BITS   = 32;
  localparam int VAR_BITS   = $clog2(LEAF_COUNT);
  localparam int NODE_COUNT = 2 * LEAF_COUNT;
  localparam int NODE_ABITS = $clog2(NODE_COUNT);
  localparam int NODE_BITS  = VAR_BITS + 1;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SETKEY = 2'd2;

  // one tree node: valid mark plus winning variable
  typedef struct packed {
    logic                valid;
    logic [VAR_BITS-1:0] vidx;
  } node_t;

  // commands from controller to datapath
  typedef struct packed {
    logic in_ready;
    logic clr_wr;
    logic rd_leaf;
    logic rd_sib;
    logic rd_key_v;
    logic rd_key_sib;
    logic rm_start;
    logic ins_leaf;
    logic ld_kself;
    logic sk_commit;
    logic par_self;
    logic par_sib;
    logic set_present;
    logic set_underflow;
    logic load_out;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       in_valid;
    logic [1:0] act;
    logic       root_valid;
    logic       clear_last;
    logic       node_valid;
    logic       at_root;
    logic       perc_win;
    logic       take_sib;
    logic       key_drop;
    logic       out_free;
  } status_t;

endpackage

@@ hw/rtl/ttmq_ram.sv @@
// ----------------------------------------------------------------------------
// ttmq_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ttmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/ttmq_datapath.sv @@
// ----------------------------------------------------------------------------
// ttmq_datapath: tree and key storage with the path walk registers
// Holds both rams, the walk cursor, the current contender and the result word.
// ----------------------------------------------------------------------------
module ttmq_datapath
  import ttmq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        s_axis_tvalid,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);

  logic [1:0]            act_q;
  logic [VAR_BITS-1:0]   v_q;
  logic [KEY_BITS-1:0]   key_in_q;
  logic [NODE_ABITS-1:0] at_q;
  node_t                 self_q, sib_q, root_q, removed_q;
  logic [KEY_BITS-1:0]   kself_q;
  logic                  present_q, underflow_q;
  logic [NODE_ABITS-1:0] clr_cnt_q;
  logic                  out_valid_q;
  logic [15:0]           out_data_q;

  logic                  tree_we;
  logic [NODE_ABITS-1:0] tree_waddr, tree_raddr;
  node_t                 tree_wdata, tree_rdata;
  logic                  key_we;
  logic [VAR_BITS-1:0]   key_waddr, key_raddr;
  logic [KEY_BITS-1:0]   key_wdata, key_rdata;
  logic                  accept;
  logic [NODE_ABITS-1:0] leaf_addr;

  assign accept    = cmd_i.in_ready & s_axis_tvalid;
  assign leaf_addr = {1'b1, v_q};

  // tree write port select
  always_comb begin
    tree_we    = 1'b1;
    tree_waddr = at_q >> 1;
    tree_wdata = self_q;
    if (cmd_i.clr_wr) begin
      tree_waddr = clr_cnt_q;
      tree_wdata = '0;
    end else if (cmd_i.rm_start) begin
      tree_waddr = {1'b1, root_q.vidx};
      tree_wdata = '0;
    end else if (cmd_i.ins_leaf) begin
      tree_waddr = leaf_addr;
      tree_wdata = '{valid: 1'b1, vidx: v_q};
    end else if (cmd_i.par_sib) begin
      tree_wdata = sib_q;
    end else if (!cmd_i.par_self) begin
      tree_we = 1'b0;
    end
  end

  assign tree_raddr = cmd_i.rd_leaf ? leaf_addr : (at_q ^ NODE_ABITS'(1));

  // key store ports
  assign key_we    = cmd_i.clr_wr | cmd_i.sk_commit;
  assign key_waddr = cmd_i.clr_wr ? clr_cnt_q[VAR_BITS-1:0] : v_q;
  assign key_wdata = cmd_i.clr_wr ? '0 : key_in_q;
  assign key_raddr = cmd_i.rd_key_sib ? tree_rdata.vidx : v_q;

  ttmq_ram #(.WIDTH(NODE_BITS), .DEPTH(NODE_COUNT)) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (tree_we),
    .waddr_i (tree_waddr),
    .wdata_i (tree_wdata),
    .raddr_i (tree_raddr),
    .rdata_o (tree_rdata)
  );

  ttmq_ram #(.WIDTH(KEY_BITS), .DEPTH(LEAF_COUNT)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // input word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= s_axis_tuser;
      v_q      <= s_axis_tdata[VAR_BITS-1:0];
      key_in_q <= s_axis_tdata[VAR_BITS +: KEY_BITS];
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rm_start) begin
      at_q   <= {1'b1, root_q.vidx};
      self_q <= '0;
    end else if (cmd_i.ins_leaf || cmd_i.sk_commit) begin
      at_q   <= leaf_addr;
      self_q <= '{valid: 1'b1, vidx: v_q};
    end else if (cmd_i.par_sib) begin
      at_q   <= at_q >> 1;
      self_q <= sib_q;
    end else if (cmd_i.par_self) begin
      at_q   <= at_q >> 1;
    end
    if (cmd_i.ld_kself || cmd_i.par_sib) begin
      kself_q <= key_rdata;
    end else if (cmd_i.sk_commit) begin
      kself_q <= key_in_q;
    end
    if (cmd_i.rd_key_sib) begin
      sib_q <= tree_rdata;
    end
  end

  // control state: root mirror, clear counter, result flags, output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= '0;
      clr_cnt_q   <= '0;
      present_q   <= 1'b0;
      underflow_q <= 1'b0;
      removed_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (tree_we && tree_waddr == NODE_ABITS'(1)) begin
        root_q <= tree_wdata;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + NODE_ABITS'(1);
      end
      if (accept) begin
        present_q   <= 1'b0;
        underflow_q <= 1'b0;
        removed_q   <= '0;
      end
      if (cmd_i.set_present) begin
        present_q <= 1'b1;
      end
      if (cmd_i.set_underflow) begin
        underflow_q <= 1'b1;
      end
      if (cmd_i.rm_start) begin
        removed_q <= root_q;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {2'b00, ~root_q.valid, present_q, underflow_q,
                        removed_q.valid, removed_q.vidx};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // status toward the controller
  assign status_o.in_valid   = s_axis_tvalid;
  assign status_o.act        = act_q;
  assign status_o.root_valid = root_q.valid;
  assign status_o.clear_last = (clr_cnt_q == NODE_ABITS'(NODE_COUNT - 1));
  assign status_o.node_valid = tree_rdata.valid;
  assign status_o.at_root    = (at_q == NODE_ABITS'(1));
  assign status_o.perc_win   = (kself_q > key_rdata);
  assign status_o.take_sib   = !self_q.valid || (key_rdata > kself_q);
  assign status_o.key_drop   = (key_in_q < key_rdata);
  assign status_o.out_free   = !out_valid_q || m_axis_tready;

endmodule

@@ hw/rtl/ttmq_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttmq_ctrl: sequencer for insert, remove maximum and set key
// Steps the datapath through the clear sweep and the leaf to root walks.
// ----------------------------------------------------------------------------
module ttmq_ctrl
  import ttmq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DISP     = 4'd2;
  localparam logic [3:0] ST_INS_LEAF = 4'd3;
  localparam logic [3:0] ST_INS_KEY  = 4'd4;
  localparam logic [3:0] ST_SK_RD    = 4'd5;
  localparam logic [3:0] ST_SIB_RD   = 4'd6;
  localparam logic [3:0] ST_SIB_WAIT = 4'd7;
  localparam logic [3:0] ST_SIB_KEY  = 4'd8;
  localparam logic [3:0] ST_DONE     = 4'd9;

  logic [3:0] state_q, state_d;
  logic       replay_q, replay_d;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    replay_d = replay_q;
    cmd_o    = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) state_d = ST_DISP;
      end
      ST_DISP: begin
        case (status_i.act)
          ACT_INSERT: begin
            cmd_o.rd_leaf = 1'b1;
            state_d       = ST_INS_LEAF;
          end
          ACT_REMOVE: begin
            if (status_i.root_valid) begin
              cmd_o.rm_start = 1'b1;
              replay_d       = 1'b1;
              state_d        = ST_SIB_RD;
            end else begin
              cmd_o.set_underflow = 1'b1;
              state_d             = ST_DONE;
            end
          end
          ACT_SETKEY: begin
            cmd_o.rd_leaf  = 1'b1;
            cmd_o.rd_key_v = 1'b1;
            state_d        = ST_SK_RD;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_INS_LEAF: begin
        if (status_i.node_valid) begin
          cmd_o.set_present = 1'b1;
          state_d           = ST_DONE;
        end else begin
          cmd_o.ins_leaf = 1'b1;
          cmd_o.rd_key_v = 1'b1;
          state_d        = ST_INS_KEY;
        end
      end
      ST_INS_KEY: begin
        cmd_o.ld_kself = 1'b1;
        replay_d       = 1'b0;
        state_d        = ST_SIB_RD;
      end
      ST_SK_RD: begin
        cmd_o.sk_commit = 1'b1;
        if (status_i.node_valid) begin
          cmd_o.set_present = 1'b1;
          replay_d          = status_i.key_drop;
          state_d           = ST_SIB_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SIB_RD: begin
        if (status_i.at_root) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_sib = 1'b1;
          state_d      = ST_SIB_WAIT;
        end
      end
      ST_SIB_WAIT: begin
        if (status_i.node_valid) begin
          cmd_o.rd_key_sib = 1'b1;
          state_d          = ST_SIB_KEY;
        end else begin
          cmd_o.par_self = 1'b1;
          state_d        = ST_SIB_RD;
        end
      end
      ST_SIB_KEY: begin
        if (replay_q) begin
          cmd_o.par_sib  = status_i.take_sib;
          cmd_o.par_self = !status_i.take_sib;
          state_d        = ST_SIB_RD;
        end else if (status_i.perc_win) begin
          cmd_o.par_self = 1'b1;
          state_d        = ST_SIB_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      replay_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      replay_q <= replay_d;
    end
  end

  // no input word is taken during the clear sweep
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !cmd_o.in_ready)
    else $error("input ready during clear sweep");

  // a parent write takes either self or sibling, never both
  a_one_parent_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.par_self && cmd_o.par_sib))
    else $error("two parent writes in one cycle");

  // the result word is loaded only into a free output register
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("result loaded over a waiting word");

  // after a result is loaded the sequencer is back at rest
  a_idle_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> state_q == ST_IDLE)
    else $error("sequencer not idle after result");

endmodule

@@ hw/rtl/tournament_tree_max_queue_top.sv @@
// ----------------------------------------------------------------------------
// tournament_tree_max_queue_top: max priority queue over variable indices
// Tournament tree of winners with a per variable key store.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one action word: tuser holds the action (insert, remove
//   maximum, set key), tdata the variable index and the key. m_axis returns
//   one result word per action word, in order.
//   One action is worked at a time. Each tree level steps through a sibling
//   node read from the tree ram, then, if that node is valid, the sibling key
//   read from the key ram; each ram has a single read port. A new word is
//   taken only after the result word of the last one is loaded.
//   After reset a clearing pass writes every tree node empty and every key
//   zero; s_axis_tready stays low during it.
//   The result word sits in an output register; when the receiver stalls the
//   block finishes its walk and then waits with s_axis_tready low until the
//   word is taken.
// ----------------------------------------------------------------------------
module tournament_tree_max_queue_top
  import ttmq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // var_index[9:0], key_value[41:10], zero
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // removed_var[9:0], removed_valid[10],
                                     // underflow[11], was_present[12],
                                     // now_empty[13], zero
);

  cmd_t    cmd;
  status_t status;

  ttmq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ttmq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

@@ test/tournament_tree_max_queue_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tournament_tree_max_queue_top_tb: self-checking bench of the max queue
// Drives insert, remove maximum, set key and undefined action words, predicts
// each result word with a behavioral winner tree and compares every field in order.
// ----------------------------------------------------------------------------
module tournament_tree_max_queue_top_tb
  import ttmq_pkg::*;
();

  localparam int WATCH_LIMIT = 20000;

  // action code with no operation
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic                now_empty;
    logic                was_present;
    logic                underflow;
    logic                removed_valid;
    logic [VAR_BITS-1:0] removed_var;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  // behavioral copy of the queue
  node_t               tree_q [NODE_COUNT];
  logic [KEY_BITS-1:0] key_q  [LEAF_COUNT];
  result_t             pending_q [$];

  int n_mismatch;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;
  int quiet_cycles;

  tournament_tree_max_queue_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [KEY_BITS-1:0] key_at(logic [VAR_BITS-1:0] v);
    return key_q[v];
  endfunction

  // walk a variable up from its leaf while it beats the sibling
  function automatic void climb(logic [VAR_BITS-1:0] v);
    int at;
    node_t sib;
    at = int'(v) + LEAF_COUNT;
    while (at > 1) begin
      sib = tree_q[at ^ 1];
      if (!sib.valid || key_at(v) > key_at(sib.vidx)) begin
        tree_q[at >> 1] = '{valid: 1'b1, vidx: v};
        at = at >> 1;
      end else begin
        break;
      end
    end
  endfunction

  // recompute every winner from a leaf to the root
  function automatic void replay(int leaf);
    int at;
    node_t me;
    node_t sib;
    for (at = leaf; at > 1; at = at >> 1) begin
      me  = tree_q[at];
      sib = tree_q[at ^ 1];
      if (sib.valid && (!me.valid || key_at(sib.vidx) > key_at(me.vidx)))
        tree_q[at >> 1] = sib;
      else
        tree_q[at >> 1] = me;
    end
  endfunction

  // expected result word of one action
  function automatic result_t queue_action(logic [1:0] act, logic [VAR_BITS-1:0] v,
                                           logic [31:0] key);
    result_t r;
    int leaf;
    logic [KEY_BITS-1:0] old;
    r = '0;
    leaf = int'(v) + LEAF_COUNT;
    case (act)
      ACT_INSERT: begin
        if (tree_q[leaf].valid) begin
          r.was_present = 1'b1;
        end else begin
          tree_q[leaf] = '{valid: 1'b1, vidx: v};
          climb(v);
        end
      end
      ACT_REMOVE: begin
        if (!tree_q[1].valid) begin
          r.underflow = 1'b1;
        end else begin
          r.removed_var   = tree_q[1].vidx;
          r.removed_valid = 1'b1;
          leaf = int'(tree_q[1].vidx) + LEAF_COUNT;
          tree_q[leaf] = '0;
          replay(leaf);
        end
      end
      ACT_SETKEY: begin
        old = key_q[v];
        key_q[v] = key;
        if (tree_q[leaf].valid) begin
          r.was_present = 1'b1;
          if (key < old) replay(leaf);
          else climb(v);
        end
      end
      default: ;
    endcase
    r.now_empty = !tree_q[1].valid;
    return r;
  endfunction

  // send one action word and record its expected result
  task automatic send_word(logic [1:0] act, logic [VAR_BITS-1:0] v, logic [31:0] key);
    result_t exp_r;
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'd0, key, v};
    do @(posedge clk_i); while (!s_axis_tready);
    exp_r = queue_action(act, v, key);
    pending_q = {pending_q, exp_r};
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // receiver stall pattern plus long hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[13:0];
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want || m_axis_tdata[15:14] !== 2'b00) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"mismatch: var exp %0d got %0d, valid %b/%b, underflow %b/%b,",
                      " present %b/%b, empty %b/%b"},
                     want.removed_var, got.removed_var,
                     want.removed_valid, got.removed_valid,
                     want.underflow, got.underflow, want.was_present, got.was_present,
                     want.now_empty, got.now_empty);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCH_LIMIT) begin
      $display("tournament_tree_max_queue_top_tb failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(ACT_REMOVE, 10'd0, 32'd0);                 // remove from empty queue
    send_word(ACT_NONE, 10'd5, 32'd7);                   // undefined action
    send_word(ACT_SETKEY, 10'd1023, 32'hFFFF_FFFF);      // key of absent variable
    send_word(ACT_INSERT, 10'd0, 32'd0);
    send_word(ACT_INSERT, 10'd1023, 32'hFFFF_FFFF);
    send_word(ACT_INSERT, 10'd0, 32'd0);                 // insert of present variable
    send_word(ACT_INSERT, 10'd512, 32'h0);
    send_word(ACT_SETKEY, 10'd512, 32'hFFFF_FFFF);       // tie keeps incumbent
    send_word(ACT_SETKEY, 10'd1023, 32'd3);              // key falls while present
    send_word(ACT_SETKEY, 10'd0, 32'h8000_0000);
    send_word(ACT_NONE, 10'd1023, 32'hFFFF_FFFF);
    send_word(ACT_REMOVE, 10'd0, 32'd0);
    send_word(ACT_REMOVE, 10'd0, 32'd0);
    send_word(ACT_REMOVE, 10'd0, 32'd0);
    send_word(ACT_REMOVE, 10'd0, 32'd0);
    wait_drained();
  endtask

  // mostly valid actions over a small variable pool, some wide ones
  task automatic test_random(int count);
    int sel;
    logic [VAR_BITS-1:0] v;
    logic [31:0] key;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99, 0);
      v   = ($urandom_range(3, 0) == 0) ? 10'($urandom) : 10'($urandom_range(40, 0));
      key = ($urandom_range(1, 0) == 0) ? $urandom : 32'($urandom_range(15, 0));
      if (sel < 38)      send_word(ACT_INSERT, v, key);
      else if (sel < 66) send_word(ACT_REMOVE, 10'($urandom), key);
      else if (sel < 97) send_word(ACT_SETKEY, v, key);
      else               send_word(ACT_NONE, v, key);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 600;
    test_random(30);
  endtask

  initial begin
    n_mismatch     = 0;
    quiet_cycles   = 0;
    hold_off       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    for (int n = 0; n < NODE_COUNT; n++) tree_q[n] = '0;
    for (int k = 0; k < LEAF_COUNT; k++) key_q[k] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(110);
    send_idle_pct = 49;
    test_random(100);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    test_random(100);
    send_idle_pct = 25;
    recv_stall_pct = 25;
    test_random(100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    if (n_mismatch == 0)
      $display("tournament_tree_max_queue_top_tb passed");
    else
      $display("tournament_tree_max_queue_top_tb failed");
    $finish;
  end

endmodule

@@ tournament_tree_max_queue_top.f @@
hw/rtl/ttmq_pkg.sv
hw/rtl/ttmq_ram.sv
hw/rtl/ttmq_datapath.sv
hw/rtl/ttmq_ctrl.sv
hw/rtl/tournament_tree_max_queue_top.sv
test/tournament_tree_max_queue_top_tb.sv
